/* rtl/ppcce_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the closure extension check.
package ppcce_pkg;

  // Table geometry and set capacity
  localparam int NUM_ITEMS   = 64;
  localparam int TRANS_WORDS = 16;
  localparam int MAX_SET     = 64;

  // Field and counter widths
  localparam int ITEM_W  = $clog2(NUM_ITEMS);
  localparam int WORD_W  = $clog2(TRANS_WORDS);
  localparam int NI_W    = 7;                     // items_in_use, column counter
  localparam int NW_W    = 5;                     // words_in_use
  localparam int SET_W   = 7;                     // set_count, room left
  localparam int DATA_W  = 64;
  localparam int MODE_W  = 2;
  localparam int COL_AW  = ITEM_W + WORD_W;
  localparam int COL_DEPTH = NUM_ITEMS * TRANS_WORDS;

  // Stream word layout
  localparam int IN_FIELDS_W  = ITEM_W + WORD_W + DATA_W + 1;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + ITEM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ITEMS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_USE = 1'b1;
  localparam logic [NI_W-1:0] ITEMS_RESET = NI_W'(64);
  localparam logic [NW_W-1:0] WORDS_RESET = NW_W'(16);

  // Input word kinds
  localparam logic [MODE_W-1:0] MODE_TABLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUPPORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEMBER  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

  // Query set up by the top level at start
  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [NI_W-1:0]   nitems;
    logic [NW_W-1:0]   nwords;
    logic [SET_W-1:0]  room;
    logic              full;
  } query_t;

  // One result word
  typedef struct packed {
    logic              accepted;
    logic [ITEM_W-1:0] ext_item;
    logic              last;
  } result_t;

endpackage

/* rtl/ppcce_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ppcce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ppcce_scan.sv */
`timescale 1ns / 1ps
// Query sequencer: walks the columns word by word through one shared cover compare.
module ppcce_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  ppcce_pkg::query_t                   query,
  input  logic [ppcce_pkg::NUM_ITEMS-1:0]     membership,
  output logic                                busy,
  output logic [ppcce_pkg::COL_AW-1:0]        col_raddr,
  output logic [ppcce_pkg::WORD_W-1:0]        sup_raddr,
  input  logic [ppcce_pkg::DATA_W-1:0]        col_rdata,
  input  logic [ppcce_pkg::DATA_W-1:0]        sup_rdata,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ppcce_pkg::result_t                  res
);
  import ppcce_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NEXT  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]        state;
  logic [NI_W-1:0]   idx;
  logic [WORD_W-1:0] word;
  logic [ITEM_W-1:0] item_q;
  logic [NI_W-1:0]   nitems_q;
  logic [NW_W-1:0]   nwords_q;
  logic [SET_W-1:0]  room;
  logic              new_done;
  logic              cov_fail;
  logic              rd_valid_d;
  result_t           pend;
  result_t           out;
  logic              out_valid;

  logic              mismatch;
  logic              fail_now;
  logic              slot_free;
  logic              out_load;
  logic [NI_W-1:0]   item_ext;

  // Shared compare: a support bit missing from the column word
  assign mismatch  = |(sup_rdata & ~col_rdata);
  assign fail_now  = cov_fail | (rd_valid_d & mismatch);
  assign slot_free = !out_valid || res_ready;
  assign out_load  = ((state == S_PUSH) || (state == S_FLUSH)) && slot_free;
  assign item_ext  = NI_W'(item_q);

  // Read addresses follow the column and word counters
  assign col_raddr = {idx[ITEM_W-1:0], word};
  assign sup_raddr = word;

  assign busy      = (state != S_IDLE);
  assign res_valid = out_valid;
  assign res       = out;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rd_valid_d <= 1'b0;
      cov_fail   <= 1'b0;
    end else begin
      rd_valid_d <= (state == S_READ);
      // Clear the miss flag before each column, accumulate while its words arrive
      cov_fail   <= (state == S_NEXT) ? 1'b0 : fail_now;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && res_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_q   <= query.item;
            nitems_q <= query.nitems;
            nwords_q <= query.nwords;
            room     <= query.room;
            idx      <= '0;
            new_done <= 1'b0;
            if (query.full) begin
              pend  <= '{accepted: 1'b0, ext_item: '0, last: 1'b0};
              state <= S_FLUSH;
            end else begin
              state <= S_NEXT;
            end
          end
        end

        S_NEXT: begin
          if (!new_done && (idx >= item_ext || idx >= nitems_q)) begin
            // Lower columns passed: hold the new item as first result
            pend     <= '{accepted: 1'b1, ext_item: item_q, last: 1'b0};
            new_done <= 1'b1;
          end else if (new_done && (idx >= nitems_q || room == '0)) begin
            state <= S_FLUSH;
          end else if (membership[idx[ITEM_W-1:0]] || idx == item_ext) begin
            idx <= idx + NI_W'(1);
          end else begin
            word     <= '0;
            state    <= (nwords_q == '0) ? S_EVAL : S_READ;
          end
        end

        S_READ: begin
          // Issue one word address per cycle
          if ({1'b0, word} == nwords_q - NW_W'(1)) begin
            state <= S_EVAL;
          end else begin
            word <= word + WORD_W'(1);
          end
        end

        S_EVAL: begin
          if (idx < item_ext) begin
            if (!fail_now) begin
              pend  <= '{accepted: 1'b0, ext_item: '0, last: 1'b0};
              state <= S_FLUSH;
            end else begin
              idx   <= idx + NI_W'(1);
              state <= S_NEXT;
            end
          end else if (!fail_now) begin
            state <= S_PUSH;
          end else begin
            idx   <= idx + NI_W'(1);
            state <= S_NEXT;
          end
        end

        S_PUSH: begin
          // Release the held result, then hold the closure item just found
          if (slot_free) begin
            out       <= '{accepted: pend.accepted, ext_item: pend.ext_item, last: 1'b0};
            pend      <= '{accepted: 1'b1, ext_item: idx[ITEM_W-1:0], last: 1'b0};
            room      <= room - SET_W'(1);
            idx       <= idx + NI_W'(1);
            state     <= S_NEXT;
          end
        end

        S_FLUSH: begin
          if (slot_free) begin
            out       <= '{accepted: pend.accepted, ext_item: pend.ext_item, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A reject word is always the only and final one
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out.accepted) |-> (out.last && out.ext_item == '0))
    else $error("reject word not marked last or carries an item");

  // Closure pushes only with room left and after the new item is held
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (room != '0 && new_done && pend.accepted))
    else $error("closure push without room or before new item");

  // Evaluation sees the final word when words are compared
  a_eval_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && nwords_q != '0) |-> rd_valid_d)
    else $error("column evaluated without its last word");

  // Queries start only when the sequencer is idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("query started while busy");

endmodule

/* rtl/ppc_closure_extension_check.sv */
`timescale 1ns / 1ps
// Top level of the prefix-preserving closure extension check.
//
// Load words (table word, support word, membership bit) are taken straight into the
// stores and membership bits. A query walks the present columns in order, until it
// rejects or no room is left in the set: a member column or the new item's own column
// is skipped, any other column is compared word by word, as one word of column and
// support memory is read and compared per cycle; the scan holds while a finished
// result word waits to be taken. Query time is set by the single read port of the
// column memory and the one shared word compare.
// The input side is not ready while a query runs; a finished result waits in an
// output register and the next load or query is taken meanwhile. The column and
// support stores read as anything until written.
module ppc_closure_extension_check (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input words
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ppcce_pkg::IN_TDATA_W-1:0]      s_tdata,   // item, word_index, data_word, member
  input  logic [ppcce_pkg::MODE_W-1:0]          s_tuser,   // mode
  // Result words
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ppcce_pkg::OUT_TDATA_W-1:0]     m_tdata,   // accepted, ext_item
  output logic                                  m_tlast,
  // Configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppcce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppcce_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ppcce_pkg::*;

  logic [NI_W-1:0]      items_in_use;
  logic [NW_W-1:0]      words_in_use;
  logic [NUM_ITEMS-1:0] membership;
  logic [SET_W-1:0]     set_count;

  logic [ITEM_W-1:0]    in_item;
  logic [WORD_W-1:0]    in_word;
  logic [DATA_W-1:0]    in_data;
  logic                 in_member;
  logic                 in_acc;
  logic                 busy;
  logic                 start;
  query_t               query;
  result_t              res;
  logic [COL_AW-1:0]    col_raddr;
  logic [WORD_W-1:0]    sup_raddr;
  logic [DATA_W-1:0]    col_rdata;
  logic [DATA_W-1:0]    sup_rdata;

  // Unpack the input word
  assign in_item   = s_tdata[ITEM_W-1:0];
  assign in_word   = s_tdata[ITEM_W +: WORD_W];
  assign in_data   = s_tdata[ITEM_W+WORD_W +: DATA_W];
  assign in_member = s_tdata[ITEM_W+WORD_W+DATA_W];

  assign s_tready  = !busy;
  assign in_acc    = s_tvalid && s_tready;
  assign start     = in_acc && (s_tuser == MODE_QUERY);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      items_in_use <= ITEMS_RESET;
      words_in_use <= WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ITEMS_IN_USE: items_in_use <= cfg_data[NI_W-1:0];
        REG_WORDS_IN_USE: words_in_use <= cfg_data[NW_W-1:0];
        default: ;
      endcase
    end
  end

  // Membership bits and member count; item field always addresses a present bit
  always_ff @(posedge clk) begin
    if (rst) begin
      membership <= '0;
      set_count  <= '0;
    end else if (in_acc && s_tuser == MODE_MEMBER && membership[in_item] != in_member) begin
      membership[in_item] <= in_member;
      set_count <= in_member ? set_count + SET_W'(1) : set_count - SET_W'(1);
    end
  end

  // Clamp the registers and work out room left at query start
  always_comb begin
    query.item   = in_item;
    query.nitems = (items_in_use > NI_W'(NUM_ITEMS)) ? NI_W'(NUM_ITEMS) : items_in_use;
    query.nwords = (words_in_use > NW_W'(TRANS_WORDS)) ? NW_W'(TRANS_WORDS) : words_in_use;
    query.full   = (set_count >= SET_W'(MAX_SET));
    query.room   = SET_W'(MAX_SET - 1) - set_count;
  end

  // Column store
  ppcce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (COL_DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (in_acc && s_tuser == MODE_TABLE),
    .waddr ({in_item, in_word}),
    .wdata (in_data),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // Support words
  ppcce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TRANS_WORDS)
  ) u_sup_ram (
    .clk   (clk),
    .we    (in_acc && s_tuser == MODE_SUPPORT),
    .waddr (in_word),
    .wdata (in_data),
    .raddr (sup_raddr),
    .rdata (sup_rdata)
  );

  // Query sequencer
  ppcce_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .query      (query),
    .membership (membership),
    .busy       (busy),
    .col_raddr  (col_raddr),
    .sup_raddr  (sup_raddr),
    .col_rdata  (col_rdata),
    .sup_rdata  (sup_rdata),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  // Pack the result word
  assign m_tdata = OUT_TDATA_W'({res.ext_item, res.accepted});
  assign m_tlast = res.last;

  // Member count tracks the membership bits
  a_count: assert property (@(posedge clk) disable iff (rst)
    set_count == SET_W'($countones(membership)))
    else $error("member count out of step with membership bits");

  // A query closes the input side on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> !s_tready)
    else $error("input still ready after query start");

  // Loads leave the input side open
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser != MODE_QUERY) |=> s_tready)
    else $error("load word blocked the input side");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the closure extension check: directed table, then random phases.
module testbench;
  import ppcce_pkg::*;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 24;
  // Columns kept fully written; with more than one word compared only these are present
  localparam int DEEP_COLS = 8;

  // One row of the directed table; typed_reject marks a query whose reject word is known
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ITEM_W-1:0] item;
    logic [WORD_W-1:0] widx;
    logic [DATA_W-1:0] data;
    logic              member;
    logic              typed_reject;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [MODE_W-1:0]      s_tuser = MODE_TABLE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_ITEMS_IN_USE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state
  logic [DATA_W-1:0] column_mem [COL_DEPTH];
  logic [DATA_W-1:0] support_mem [TRANS_WORDS];
  bit                in_set [NUM_ITEMS];
  int                set_size = 0;
  logic [NI_W-1:0]   items_reg = ITEMS_RESET;
  logic [NW_W-1:0]   words_reg = WORDS_RESET;
  result_t           extensions_due [$];

  int mismatches = 0;
  int word_count = 0;
  bit calm = 1'b0;
  int ready_left = 0;

  // Settings per random phase, extremes and out-of-range values among them;
  // more than one word compared only with at most DEEP_COLS columns present
  int phase_items [PHASES] = '{64, 1, 8, 100, 2, 64, 0, 127, 8};
  int phase_words [PHASES] = '{1, 1, 5, 1, 16, 0, 0, 1, 31};

  // Directed table, run with DEEP_COLS columns of all words; rows with typed_reject set
  // expect the single reject word
  stim_row_t directed_rows [23] = '{
    '{MODE_SUPPORT, 6'd0,  4'd0,  ALL_ONES, 1'b0, 1'b0},
    '{MODE_SUPPORT, 6'd0,  4'd15, 64'd0,    1'b1, 1'b0},
    '{MODE_TABLE,   6'd0,  4'd0,  ALL_ONES, 1'b0, 1'b0},
    '{MODE_QUERY,   6'd5,  4'd0,  64'd0,    1'b0, 1'b1},
    '{MODE_QUERY,   6'd0,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_TABLE,   6'd63, 4'd0,  ALL_ONES, 1'b0, 1'b0},
    '{MODE_QUERY,   6'd0,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_MEMBER,  6'd0,  4'd0,  64'd0,    1'b1, 1'b0},
    '{MODE_QUERY,   6'd5,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_MEMBER,  6'd0,  4'd0,  64'd0,    1'b1, 1'b0},
    '{MODE_MEMBER,  6'd63, 4'd0,  64'd0,    1'b1, 1'b0},
    '{MODE_QUERY,   6'd63, 4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_MEMBER,  6'd0,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_QUERY,   6'd63, 4'd0,  64'd0,    1'b0, 1'b1},
    '{MODE_SUPPORT, 6'd0,  4'd15, ALL_ONES, 1'b0, 1'b0},
    '{MODE_QUERY,   6'd63, 4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_MEMBER,  6'd63, 4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_TABLE,   6'd63, 4'd15, ALL_ONES, 1'b0, 1'b0},
    '{MODE_QUERY,   6'd0,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_SUPPORT, 6'd0,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_SUPPORT, 6'd0,  4'd15, 64'd0,    1'b0, 1'b0},
    '{MODE_QUERY,   6'd0,  4'd0,  64'd0,    1'b0, 1'b0},
    '{MODE_QUERY,   6'd63, 4'd0,  64'd0,    1'b0, 1'b1}
  };

  ppc_closure_extension_check dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // A column covers when no support bit in the compared words is missing from it
  function automatic bit column_covers(input int col, input int n_words);
    for (int w = 0; w < n_words; w++)
      if ((support_mem[w] & ~column_mem[col * TRANS_WORDS + w]) != '0) return 1'b0;
    return 1'b1;
  endfunction

  // Work out the result words of a query and queue them
  function automatic void predict_extension(input logic [ITEM_W-1:0] query_item);
    int n_items, n_words, room, i;
    bit refused;
    result_t r;
    n_items = (items_reg > NUM_ITEMS) ? NUM_ITEMS : int'(items_reg);
    n_words = (words_reg > TRANS_WORDS) ? TRANS_WORDS : int'(words_reg);
    refused = (set_size >= MAX_SET);
    // Reject when a non-member column below the new item covers the support
    for (i = 0; i < int'(query_item) && i < n_items && !refused; i++)
      if (!in_set[i] && column_covers(i, n_words)) refused = 1'b1;
    if (refused) begin
      r.accepted = 1'b0;
      r.ext_item = '0;
      r.last     = 1'b1;
      extensions_due.push_back(r);
    end else begin
      r.accepted = 1'b1;
      r.ext_item = query_item;
      r.last     = 1'b0;
      extensions_due.push_back(r);
      room = MAX_SET - set_size - 1;
      // Closure items in ascending order, up to the room left in the set
      for (i = int'(query_item) + 1; i < n_items; i++) begin
        if (!in_set[i] && room > 0 && column_covers(i, n_words)) begin
          r.ext_item = ITEM_W'(i);
          extensions_due.push_back(r);
          room--;
        end
      end
      extensions_due[extensions_due.size() - 1].last = 1'b1;
    end
  endfunction

  // Offer one input word, wait for it to be taken, then update the predictor
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [ITEM_W-1:0] item,
                           input logic [WORD_W-1:0] widx, input logic [DATA_W-1:0] data,
                           input logic member, input logic typed_reject);
    result_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_TDATA_W'({member, data, widx, item});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    word_count++;
    case (mode)
      MODE_TABLE:   column_mem[int'(item) * TRANS_WORDS + int'(widx)] = data;
      MODE_SUPPORT: support_mem[widx] = data;
      MODE_MEMBER: begin
        if (in_set[item] != member) begin
          in_set[item] = member;
          set_size += member ? 1 : -1;
        end
      end
      default: begin
        if (typed_reject) begin
          r.accepted = 1'b0;
          r.ext_item = '0;
          r.last     = 1'b1;
          extensions_due.push_back(r);
        end else begin
          predict_extension(item);
        end
      end
    endcase
  endtask

  // Drop valid, wait for every result word, then let any load finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (extensions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, in either order
  task automatic write_config(input int n_items, input int n_words, input bit items_first);
    for (int k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      if ((k == 0) == items_first) begin
        cfg_index <= REG_ITEMS_IN_USE;
        cfg_data  <= CFG_DATA_W'(n_items);
      end else begin
        cfg_index <= REG_WORDS_IN_USE;
        cfg_data  <= CFG_DATA_W'(n_words);
      end
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if ((k == 0) == items_first) items_reg = NI_W'(n_items);
      else words_reg = NW_W'(n_words);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random sequence: noise, or a set fill, a set drain or loads, each followed by queries
  task automatic run_scenario();
    int choice, k, c, w, nw, target, start, step;
    logic [DATA_W-1:0] d;
    nw = (words_reg > TRANS_WORDS) ? TRANS_WORDS : int'(words_reg);
    choice = $urandom_range(0, 11);
    if (choice == 0) begin
      send_word(MODE_W'($urandom), ITEM_W'($urandom), WORD_W'($urandom),
                {$urandom, $urandom}, 1'($urandom), 1'b0);
    end else begin
      if (choice == 1 && set_size < 56) begin
        // Fill the set up to or near capacity
        target = $urandom_range(60, NUM_ITEMS);
        start  = $urandom_range(0, NUM_ITEMS - 1);
        step   = 2 * $urandom_range(0, 31) + 1;
        for (k = 0; k < NUM_ITEMS && set_size < target; k++)
          send_word(MODE_MEMBER, ITEM_W'(start + k * step), WORD_W'($urandom),
                    {$urandom, $urandom}, 1'b1, 1'b0);
      end else if (choice == 2 && set_size > 20) begin
        // Drain the set to a few members
        target = $urandom_range(0, 8);
        start  = $urandom_range(0, NUM_ITEMS - 1);
        step   = 2 * $urandom_range(0, 31) + 1;
        for (k = 0; k < NUM_ITEMS && set_size > target; k++)
          send_word(MODE_MEMBER, ITEM_W'(start + k * step), WORD_W'($urandom),
                    {$urandom, $urandom}, 1'b0, 1'b0);
      end else begin
        // Support words: mostly zero, some sparse, now and then full
        repeat ($urandom_range(0, 2)) begin
          w = $urandom_range(0, TRANS_WORDS - 1);
          k = $urandom_range(0, 9);
          if (k < 6) d = '0;
          else if (k < 9) d = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
          else d = ALL_ONES;
          send_word(MODE_SUPPORT, ITEM_W'($urandom), WORD_W'(w), d, 1'($urandom), 1'b0);
        end
        // Columns: make some cover the support, break others
        repeat ($urandom_range(1, 3)) begin
          c = (nw > 1) ? $urandom_range(0, DEEP_COLS - 1) : $urandom_range(0, NUM_ITEMS - 1);
          if ($urandom_range(0, 2) != 0) begin
            for (w = 0; w < nw; w++)
              if ((support_mem[w] & ~column_mem[c * TRANS_WORDS + w]) != '0)
                send_word(MODE_TABLE, ITEM_W'(c), WORD_W'(w),
                          column_mem[c * TRANS_WORDS + w] | support_mem[w], 1'($urandom), 1'b0);
          end else if (nw > 0) begin
            w = $urandom_range(0, nw - 1);
            d = (support_mem[w] != '0) ? column_mem[c * TRANS_WORDS + w] & ~support_mem[w]
                                       : {$urandom, $urandom};
            send_word(MODE_TABLE, ITEM_W'(c), WORD_W'(w), d, 1'($urandom), 1'b0);
          end
        end
        repeat ($urandom_range(0, 2))
          send_word(MODE_MEMBER, ITEM_W'($urandom), WORD_W'($urandom), {$urandom, $urandom},
                    1'($urandom), 1'b0);
      end
      // Queries, biased towards low items now and then
      repeat ($urandom_range(1, 2)) begin
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 63);
        send_word(MODE_QUERY, ITEM_W'(c), WORD_W'($urandom), {$urandom, $urandom},
                  1'($urandom), 1'b0);
      end
    end
  endtask

  // Result side stalls in bursts; none in the last phase
  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= ($urandom_range(0, 2) != 0);
      ready_left <= $urandom_range(0, 7);
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (extensions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: accepted %0b item %0d last %0b",
                   m_tdata[0], m_tdata[ITEM_W:1], m_tlast);
      end else begin
        want = extensions_due.pop_front();
        if (m_tdata[0] !== want.accepted || m_tdata[ITEM_W:1] !== want.ext_item ||
            m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected accepted %0b item %0d last %0b, got %0b %0d %0b",
                     want.accepted, want.ext_item, want.last,
                     m_tdata[0], m_tdata[ITEM_W:1], m_tlast);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int phase, phase_end, c, w, r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Write every table and support word that a query can read under the settings used:
    // all words of the deep columns, the first word of the rest
    for (c = 0; c < NUM_ITEMS; c++)
      for (w = 0; w < ((c < DEEP_COLS) ? TRANS_WORDS : 1); w++)
        send_word(MODE_TABLE, ITEM_W'(c), WORD_W'(w), {$urandom, $urandom}, 1'($urandom), 1'b0);
    for (w = 0; w < TRANS_WORDS; w++)
      send_word(MODE_SUPPORT, ITEM_W'($urandom), WORD_W'(w), '0, 1'($urandom), 1'b0);
    wait_idle();
    write_config(DEEP_COLS, TRANS_WORDS, 1'b1);
    for (r = 0; r < 23; r++)
      send_word(directed_rows[r].mode, directed_rows[r].item, directed_rows[r].widx,
                directed_rows[r].data, directed_rows[r].member, directed_rows[r].typed_reject);
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      calm = (phase == PHASES - 1);
      write_config(phase_items[phase], phase_words[phase], 1'($urandom));
      phase_end = word_count + WORDS_PER_PHASE;
      while (word_count < phase_end) run_scenario();
    end
    wait_idle();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
